// ===== hdl/replication_commit_tracker_defines.svh =====
// Assertion macros shared by the replication commit tracker RTL
`ifndef REPLICATION_COMMIT_TRACKER_DEFINES_SVH
`define REPLICATION_COMMIT_TRACKER_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define RCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define RCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/rct_pkg.sv =====
// Package: shared types and constants of the replication commit tracker
package rct_pkg;
  localparam int NUM_FOLLOWERS_DEF = 8;
  localparam int LOG_DEPTH_DEF     = 1024;
  localparam int CFG_W   = 4;
  localparam int REQ_W   = 3;
  localparam int FOL_W   = 3;
  localparam int IDX_W   = 10;
  localparam int NXT_W   = 11;
  localparam int TERM_W  = 32;
  localparam logic [CFG_W-1:0] NUM_FOLLOWERS_RST = 4'd4;

  typedef enum logic [REQ_W-1:0] {
    REQ_RESET   = 3'd0,
    REQ_WRITE   = 3'd1,
    REQ_PREPARE = 3'd2,
    REQ_RESULT  = 3'd3,
    REQ_COMMIT  = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_READ, ST_WALK_RD, ST_WALK_CHK, ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input word
    logic exec;       // apply simple state update
    logic rd_prev;    // issue term-store read for prepare append
    logic walk_init;  // start commit walk at last index
    logic walk_rd;    // issue term-store read at walk index
    logic walk_step;  // evaluate walk entry, step down
    logic out_load;   // build result word
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic walk_done;  // walk index reached held commit
    logic walk_hit;   // current entry qualifies
  } sts_t;
endpackage

// ===== hdl/rct_if.sv =====
// Interfaces: input and result channels of the replication commit tracker
interface rct_in_if;
  logic                    valid;
  logic                    ready;
  logic [rct_pkg::REQ_W-1:0]  req_type;
  logic [rct_pkg::FOL_W-1:0]  follower;
  logic [rct_pkg::IDX_W-1:0]  index;
  logic [rct_pkg::TERM_W-1:0] term;
  logic                    has_entries;
  logic                    success;
  logic [rct_pkg::IDX_W-1:0]  held_commit;
  modport source (output valid, req_type, follower, index, term, has_entries, success,
                  held_commit, input ready);
  modport sink (input valid, req_type, follower, index, term, has_entries, success,
                held_commit, output ready);
endinterface

interface rct_out_if;
  logic                    valid;
  logic                    ready;
  logic [rct_pkg::IDX_W-1:0]  commit_index;
  logic [rct_pkg::IDX_W-1:0]  prev_index;
  logic [rct_pkg::TERM_W-1:0] prev_term;
  logic [rct_pkg::NXT_W-1:0]  next_out;
  logic [rct_pkg::IDX_W-1:0]  match_out;
  modport source (output valid, commit_index, prev_index, prev_term, next_out, match_out,
                  input ready);
  modport sink (input valid, commit_index, prev_index, prev_term, next_out, match_out,
                output ready);
endinterface

// ===== hdl/rct_ctrl.sv =====
// Controller: sequences one word at a time through the datapath
`include "replication_commit_tracker_defines.svh"
module rct_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  rct_pkg::sts_t  sts,
  output rct_pkg::cmd_t  cmd
);
  rct_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rct_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      rct_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = rct_pkg::ST_EXEC;
        end
      end
      rct_pkg::ST_EXEC: begin
        unique case (sts.req)
          rct_pkg::REQ_PREPARE: begin
            cmd.rd_prev = 1'b1;
            state_nxt   = rct_pkg::ST_READ;
          end
          rct_pkg::REQ_COMMIT: begin
            cmd.walk_init = 1'b1;
            state_nxt     = rct_pkg::ST_WALK_RD;
          end
          default: begin
            cmd.exec  = 1'b1;
            state_nxt = rct_pkg::ST_READ;
          end
        endcase
      end
      rct_pkg::ST_READ: state_nxt = rct_pkg::ST_OUT;
      rct_pkg::ST_WALK_RD: begin
        if (sts.walk_done) begin
          state_nxt = rct_pkg::ST_OUT;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = rct_pkg::ST_WALK_CHK;
        end
      end
      rct_pkg::ST_WALK_CHK: begin
        cmd.walk_step = 1'b1;
        state_nxt = sts.walk_hit ? rct_pkg::ST_OUT : rct_pkg::ST_WALK_RD;
      end
      rct_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rct_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rct_pkg::ST_IDLE;
    endcase
  end

  `RCT_ASSERT_IMP(a_ready_idle, in_ready, state_r == rct_pkg::ST_IDLE, "ready outside idle")
  `RCT_ASSERT_NXT(a_load_valid, cmd.out_load, out_valid, "result not raised")
  `RCT_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.exec, cmd.rd_prev, cmd.walk_init,
    cmd.walk_rd, cmd.walk_step}), "overlapping commands")
endmodule

// ===== hdl/rct_dp.sv =====
// Datapath: follower indices, term store, commit walk, result register
`include "replication_commit_tracker_defines.svh"
module rct_dp #(
  parameter int NUM_FOLLOWERS = rct_pkg::NUM_FOLLOWERS_DEF,
  parameter int LOG_DEPTH     = rct_pkg::LOG_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [rct_pkg::CFG_W-1:0]  cfg_data,
  input  logic [rct_pkg::REQ_W-1:0]  in_req_type,
  input  logic [rct_pkg::FOL_W-1:0]  in_follower,
  input  logic [rct_pkg::IDX_W-1:0]  in_index,
  input  logic [rct_pkg::TERM_W-1:0] in_term,
  input  logic                       in_has_entries,
  input  logic                       in_success,
  input  logic [rct_pkg::IDX_W-1:0]  in_held_commit,
  input  rct_pkg::cmd_t              cmd,
  output rct_pkg::sts_t              sts,
  output logic [rct_pkg::IDX_W-1:0]  out_commit_index,
  output logic [rct_pkg::IDX_W-1:0]  out_prev_index,
  output logic [rct_pkg::TERM_W-1:0] out_prev_term,
  output logic [rct_pkg::NXT_W-1:0]  out_next_out,
  output logic [rct_pkg::IDX_W-1:0]  out_match_out
);
  localparam int IW = rct_pkg::IDX_W;
  localparam int NW = rct_pkg::NXT_W;
  localparam int TW = rct_pkg::TERM_W;
  localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CW = $clog2(NUM_FOLLOWERS + 2);
  localparam int SW = (NUM_FOLLOWERS > 1) ? $clog2(NUM_FOLLOWERS) : 1;

  logic [rct_pkg::CFG_W-1:0] nf_r;
  logic [NW-1:0] next_r  [NUM_FOLLOWERS];
  logic [IW-1:0] match_r [NUM_FOLLOWERS];
  logic [IW-1:0] last_r;
  logic [TW-1:0] mem [LOG_DEPTH];
  logic [TW-1:0] rd_r;
  logic          rd_ok_r;

  logic [rct_pkg::REQ_W-1:0] req_r;
  logic [rct_pkg::FOL_W-1:0] fol_r;
  logic [IW-1:0] idx_r, held_r, walk_r, commit_r, prev_idx_r;
  logic [TW-1:0] term_r;
  logic          has_r, succ_r;

  logic fol_ok;
  logic [SW-1:0] fol_sel;
  logic [NW-1:0] nx_sel;
  logic [IW-1:0] pv_idx;
  logic [IW-1:0] rd_addr;
  logic [CW-1:0] nf_used, replicas, half;
  logic [rct_pkg::CFG_W:0] nf_ext;

  assign fol_ok  = 32'(fol_r) < NUM_FOLLOWERS;
  assign fol_sel = SW'(fol_r);
  assign nx_sel  = fol_ok ? next_r[fol_sel] : '0;
  assign pv_idx  = (nx_sel > 0) ? IW'(nx_sel - NW'(1)) : '0;
  assign rd_addr = cmd.rd_prev ? pv_idx : walk_r;

  assign nf_ext  = {1'b0, nf_r};
  assign nf_used = (32'(nf_r) > NUM_FOLLOWERS) ? CW'(NUM_FOLLOWERS) : CW'(nf_ext);
  assign half    = CW'((32'(nf_used) + 1) >> 1);

  // count replicas of the walk entry: leader plus matching followers
  always_comb begin
    replicas = CW'(1);
    for (int f = 0; f < NUM_FOLLOWERS; f++) begin
      if (f < 32'(nf_used) && match_r[f] >= walk_r) replicas = replicas + CW'(1);
    end
  end

  assign sts.req       = req_r;
  assign sts.walk_done = !(walk_r > held_r);
  assign sts.walk_hit  = (rd_ok_r ? rd_r : '0) == term_r && replicas > half;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      fol_r  <= in_follower;
      idx_r  <= in_index;
      term_r <= in_term;
      has_r  <= in_has_entries;
      succ_r <= in_success;
      held_r <= in_held_commit;
    end
    if (cmd.walk_init) begin
      walk_r   <= last_r;
      commit_r <= held_r;
    end
    if (cmd.walk_step && !sts.walk_hit) walk_r <= walk_r - IW'(1);
    if (cmd.walk_step && sts.walk_hit) commit_r <= walk_r;
    if (cmd.rd_prev) prev_idx_r <= pv_idx;
  end

  // term store, one read port registered
  always_ff @(posedge clk) begin
    if (cmd.exec && req_r == rct_pkg::REQ_WRITE && 32'(idx_r) < LOG_DEPTH)
      mem[AW'(idx_r)] <= term_r;
    if (cmd.rd_prev || cmd.walk_rd) begin
      rd_ok_r <= 32'(rd_addr) < LOG_DEPTH;
      rd_r    <= mem[AW'(rd_addr)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r   <= rct_pkg::NUM_FOLLOWERS_RST;
      last_r <= '0;
      for (int f = 0; f < NUM_FOLLOWERS; f++) begin
        next_r[f]  <= NW'(1);
        match_r[f] <= '0;
      end
    end else begin
      if (cfg_we) nf_r <= cfg_data;
      if (cmd.exec) begin
        case (req_r)
          rct_pkg::REQ_RESET: begin
            for (int f = 0; f < NUM_FOLLOWERS; f++) begin
              next_r[f]  <= NW'(idx_r) + NW'(1);
              match_r[f] <= '0;
            end
          end
          rct_pkg::REQ_WRITE: if (32'(idx_r) < LOG_DEPTH) last_r <= idx_r;
          rct_pkg::REQ_RESULT: begin
            for (int f = 0; f < NUM_FOLLOWERS; f++) begin
              if (fol_ok && 32'(fol_r) == f) begin
                if (succ_r) begin
                  if (has_r) begin
                    match_r[f] <= idx_r;
                    next_r[f]  <= NW'(idx_r) + NW'(1);
                  end
                end else if (next_r[f] > NW'(1)) begin
                  next_r[f] <= next_r[f] - NW'(1);
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_commit_index <= (req_r == rct_pkg::REQ_COMMIT) ? commit_r : '0;
      out_prev_index   <= (req_r == rct_pkg::REQ_PREPARE && fol_ok) ? prev_idx_r : '0;
      out_prev_term    <= (req_r == rct_pkg::REQ_PREPARE && fol_ok && prev_idx_r != '0
                           && rd_ok_r) ? rd_r : '0;
      out_next_out     <= nx_sel;
      out_match_out    <= fol_ok ? match_r[fol_sel] : '0;
    end
  end

  `RCT_ASSERT_NXT(a_walk_down, cmd.walk_step && !sts.walk_hit,
    walk_r == $past(walk_r) - IW'(1), "walk did not step down")
  `RCT_ASSERT_IMP(a_commit_floor, cmd.out_load && req_r == rct_pkg::REQ_COMMIT,
    commit_r >= held_r, "commit below held index")
  `RCT_ASSERT_IMP(a_next_pos, cmd.out_load && fol_ok, nx_sel != '0, "next index zero")
endmodule

// ===== hdl/replication_commit_tracker.sv =====
// Top level: leader-side replication and commit index tracker
// Usage:
//   in  : one request word per handshake (valid & ready). req_type selects reset
//         follower indices, log write, prepare append, append result or commit query.
//   out : one result word per request, held until out.ready.
//   cfg : cfg_we writes num_followers (reset 4); write only while idle.
// Sequencing: one word at a time. Reset, write, prepare append and result words pass
//   through the exec, read and out states; the out state loads the result, raises
//   out.valid and returns to idle, where the next word is taken. A commit query steps
//   down from the last index, for each index one term-store read, then a replica count
//   over the follower match indices. It ends at the first hit or at the held commit
//   index.
// Reset (rst_n low, synchronous): next indices go to 1, match indices and last index
//   to 0, num_followers to 4. The term store is not cleared; the user must write entries
//   before they are read, as the block itself does not enforce it.
// Stall: a result word waits in the output register; the next request is accepted
//   in idle but its result is not loaded until the previous word is taken.
module replication_commit_tracker #(
  parameter int NUM_FOLLOWERS = rct_pkg::NUM_FOLLOWERS_DEF,
  parameter int LOG_DEPTH     = rct_pkg::LOG_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [rct_pkg::CFG_W-1:0] cfg_data,
  rct_in_if.sink                    in_ch,
  rct_out_if.source                 out_ch
);
  rct_pkg::cmd_t cmd;
  rct_pkg::sts_t sts;

  // sequence the request through the datapath
  rct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold state, term store and result register
  rct_dp #(.NUM_FOLLOWERS(NUM_FOLLOWERS), .LOG_DEPTH(LOG_DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_req_type      (in_ch.req_type),
    .in_follower      (in_ch.follower),
    .in_index         (in_ch.index),
    .in_term          (in_ch.term),
    .in_has_entries   (in_ch.has_entries),
    .in_success       (in_ch.success),
    .in_held_commit   (in_ch.held_commit),
    .cmd              (cmd),
    .sts              (sts),
    .out_commit_index (out_ch.commit_index),
    .out_prev_index   (out_ch.prev_index),
    .out_prev_term    (out_ch.prev_term),
    .out_next_out     (out_ch.next_out),
    .out_match_out    (out_ch.match_out)
  );
endmodule
